>>> design/gks_pkg.sv
// Package for the Gaussian kernel similarity block.
// Holds field widths, the register reset value, exponent constants, the 2^(-i/16) table
// and the pipeline control struct. No dependencies.
package gks_pkg;

    localparam int SLOT_DIMS      = 4;
    localparam int FIELD_W        = 16;
    localparam int CFG_W          = 32;
    localparam int SIM_W          = 16;

    localparam int GKS_DIMS       = 4;
    localparam int GKS_COORD_BITS = 16;

    localparam logic [CFG_W-1:0] INV_SIGMA_RESET = 32'd16777216;

    // Exponent stage constants: x is Q.16 capped at 32.0, log2(e) in Q.16
    localparam int X_W   = 22;
    localparam int L2E_W = 17;
    localparam int Y_W   = 23;
    localparam logic [X_W-1:0]   X_CAP     = 22'h200000;
    localparam logic [L2E_W-1:0] LOG2E_Q16 = 17'd94548;

    // Table of 2^(-i/16) in Q.16, one guard entry at the end
    localparam int TAB_W = 17;
    localparam logic [TAB_W-1:0] POW2_NEG_TAB [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    // Control that travels with each beat through the pipeline
    typedef struct packed {
        logic valid;
        logic self_pair;
    } gks_ctl_t;

endpackage

>>> design/gks_pair_if.sv
// Input channel: one pair of trait points and the self-pair flag per beat.
// Depends on gks_pkg.
interface gks_pair_if import gks_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] first_c0;
    logic [FIELD_W-1:0] first_c1;
    logic [FIELD_W-1:0] first_c2;
    logic [FIELD_W-1:0] first_c3;
    logic [FIELD_W-1:0] second_c0;
    logic [FIELD_W-1:0] second_c1;
    logic [FIELD_W-1:0] second_c2;
    logic [FIELD_W-1:0] second_c3;
    logic               self_pair;

    modport source (
        output valid, first_c0, first_c1, first_c2, first_c3,
               second_c0, second_c1, second_c2, second_c3, self_pair,
        input  ready
    );
    modport sink (
        input  valid, first_c0, first_c1, first_c2, first_c3,
               second_c0, second_c1, second_c2, second_c3, self_pair,
        output ready
    );
endinterface

>>> design/gks_result_if.sv
// Output channel: one similarity value per beat.
// Depends on gks_pkg.
interface gks_result_if import gks_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SIM_W-1:0] similarity;

    modport source (output valid, similarity, input ready);
    modport sink   (input valid, similarity, output ready);
endinterface

>>> design/gks_cfg_if.sv
// Configuration write channel carrying the inv_sigma_sq register value.
// Depends on gks_pkg.
interface gks_cfg_if import gks_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] inv_sigma_sq;

    modport source (output valid, inv_sigma_sq, input ready);
    modport sink   (input valid, inv_sigma_sq, output ready);
endinterface

>>> design/gks_lane.sv
// One coordinate lane: absolute difference of two coordinates, squared and registered.
// Depends on gks_pkg.
module gks_lane import gks_pkg::*; #(
    parameter int COORD_BITS = GKS_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [FIELD_W-1:0]        a,
    input  logic [FIELD_W-1:0]        b,
    output logic [2*COORD_BITS-1:0]   sq
);

    localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

    logic [EXT_W-1:0]        a_ext;
    logic [EXT_W-1:0]        b_ext;
    logic [COORD_BITS-1:0]   a_c;
    logic [COORD_BITS-1:0]   b_c;
    logic [COORD_BITS:0]     diff;
    logic [COORD_BITS-1:0]   mag;
    logic [2*COORD_BITS-1:0] sq_reg;
    logic [2*COORD_BITS-1:0] sq_next;

    // Take the coordinate from the low bits of the field, then sign-extend by one
    always_comb
    begin
        a_ext   = EXT_W'(a);
        b_ext   = EXT_W'(b);
        a_c     = a_ext[COORD_BITS-1:0];
        b_c     = b_ext[COORD_BITS-1:0];
        diff    = {a_c[COORD_BITS-1], a_c} - {b_c[COORD_BITS-1], b_c};
        mag     = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
        sq_next = (2*COORD_BITS)'(mag) * (2*COORD_BITS)'(mag);
    end

    // Hold the square while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

>>> design/gks_merge.sv
// Merge stage: adds the squared lane differences into the squared distance d2.
// Depends on gks_pkg.
module gks_merge import gks_pkg::*; #(
    parameter int DIMS       = GKS_DIMS,
    parameter int COORD_BITS = GKS_COORD_BITS,
    parameter int D2_W       = 2*COORD_BITS + $clog2(DIMS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [DIMS-1:0][2*COORD_BITS-1:0]   sq,
    input  gks_ctl_t                            ctl_in,
    output logic [D2_W-1:0]                     d2,
    output gks_ctl_t                            ctl_out
);

    logic [D2_W-1:0] d2_reg;
    logic [D2_W-1:0] d2_next;
    gks_ctl_t        ctl_reg;

    // Sum the lanes
    always_comb
    begin
        d2_next = '0;
        for (int i = 0; i < DIMS; i++)
        begin
            d2_next = d2_next + D2_W'(sq[i]);
        end
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg <= d2_next;
        end
    end

    assign d2      = d2_reg;
    assign ctl_out = ctl_reg;

endmodule

>>> design/gks_exp.sv
// Exponent pipeline: scales d2 by 1/sigma^2, converts to base 2 and evaluates
// 2^(-y) by table, linear interpolation and shift. Depends on gks_pkg.
module gks_exp import gks_pkg::*; #(
    parameter int D2_W = 2*GKS_COORD_BITS + $clog2(GKS_DIMS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [D2_W-1:0]   d2,
    input  logic [CFG_W-1:0]  inv_sigma_sq,
    input  gks_ctl_t          ctl_in,
    output logic [SIM_W-1:0]  similarity,
    output gks_ctl_t          ctl_out
);

    localparam int LO_W = (D2_W + 1) / 2;
    localparam int HI_W = D2_W - LO_W;
    localparam int PW   = D2_W + CFG_W;

    // Stage A: partial products of d2 * inv_sigma_sq
    logic [LO_W+CFG_W-1:0] p_lo_reg;
    logic [HI_W+CFG_W-1:0] p_hi_reg;
    gks_ctl_t              ctl_a_reg;

    // Stage B: scaled exponent x, Q.16 capped at 32.0
    logic [PW-1:0]         prod;
    logic [X_W-1:0]        x_next;
    logic [X_W-1:0]        x_reg;
    gks_ctl_t              ctl_b_reg;

    // Stage C: base-2 exponent y
    logic [X_W+L2E_W-1:0]  y_prod;
    logic [Y_W-1:0]        y_reg;
    gks_ctl_t              ctl_c_reg;

    // Stage D: table lookup and interpolation product
    logic [6:0]            k_next;
    logic [4:0]            idx;
    logic [11:0]           frac;
    logic [TAB_W-1:0]      hi_val;
    logic [TAB_W-1:0]      lo_val;
    logic [11:0]           delta;
    logic [23:0]           dr_next;
    logic [23:0]           dr_reg;
    logic [TAB_W-1:0]      hi_reg;
    logic [6:0]            k_reg;
    gks_ctl_t              ctl_d_reg;

    // Stage E: interpolate, shift, saturate
    logic [TAB_W-1:0]      v;
    logic [TAB_W-1:0]      shifted;
    logic [SIM_W-1:0]      sim_next;
    logic [SIM_W-1:0]      sim_reg;
    gks_ctl_t              ctl_e_reg;

    // Combine partial products and cap x; anything at or above 2^45 saturates
    always_comb
    begin
        prod   = PW'(p_lo_reg) + (PW'(p_hi_reg) << LO_W);
        x_next = (|prod[PW-1:45]) ? X_CAP : X_W'(prod[44:24]);
    end

    assign y_prod = (X_W+L2E_W)'(x_reg) * (X_W+L2E_W)'(LOG2E_Q16);

    // Split y into shift, table index and interpolation fraction
    always_comb
    begin
        k_next  = y_reg[Y_W-1:16];
        idx     = {1'b0, y_reg[15:12]};
        frac    = y_reg[11:0];
        hi_val  = POW2_NEG_TAB[idx];
        lo_val  = POW2_NEG_TAB[idx + 5'd1];
        delta   = 12'(hi_val - lo_val);
        dr_next = 24'(delta) * 24'(frac);
    end

    // Finish interpolation; a shift of 17 or more clears the 17-bit value
    always_comb
    begin
        v       = hi_reg - TAB_W'(dr_reg[23:12]);
        shifted = v >> k_reg;
        if (ctl_d_reg.self_pair)
        begin
            sim_next = '0;
        end
        else if (shifted[TAB_W-1])
        begin
            sim_next = '1;
        end
        else
        begin
            sim_next = shifted[SIM_W-1:0];
        end
    end

    // Advance control through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
            ctl_e_reg <= ctl_d_reg;
        end
    end

    // Advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg <= (LO_W+CFG_W)'(d2[LO_W-1:0]) * (LO_W+CFG_W)'(inv_sigma_sq);
            p_hi_reg <= (HI_W+CFG_W)'(d2[D2_W-1:LO_W]) * (HI_W+CFG_W)'(inv_sigma_sq);
            x_reg    <= x_next;
            y_reg    <= y_prod[X_W+L2E_W-1:16];
            dr_reg   <= dr_next;
            hi_reg   <= hi_val;
            k_reg    <= k_next;
            sim_reg  <= sim_next;
        end
    end

    assign similarity = sim_reg;
    assign ctl_out    = ctl_e_reg;

endmodule

>>> design/gaussian_kernel_similarity.sv
// Gaussian kernel similarity exp(-|p-q|^2 / sigma^2) between two trait points.
// Depends on gks_pkg, gks_pair_if, gks_result_if, gks_cfg_if, gks_lane, gks_merge, gks_exp.
//
// Usage:
//   pair   : one beat carries two points (DIMS signed coordinates each, low
//            COORD_BITS bits of each field) and the self_pair flag.
//   result : one beat per pair, similarity as unsigned Q0.16, 65535 at 1.0;
//            0 for a self pair.
//   cfg    : writes inv_sigma_sq (Q8.24); always ready. Write only while idle.
// Pipeline: seven register stages (lane square, merge, two multiply stages, base-2
//   scale, table, shift); the first stage loads at the edge that accepts a pair.
// Throughput: one pair per cycle unless the result stalls; the DIMS lanes run side by side.
// Reset: all stages empty, inv_sigma_sq back to 1.0.
// Stall: while result is valid and not taken, the whole pipeline holds and
//   pair.ready drops; it rises again in the cycle the result is taken.
module gaussian_kernel_similarity import gks_pkg::*; #(
    parameter int DIMS       = GKS_DIMS,
    parameter int COORD_BITS = GKS_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    gks_pair_if.sink      pair,
    gks_result_if.source  result,
    gks_cfg_if.sink       cfg
);

    localparam int SQ_W = 2*COORD_BITS;
    localparam int D2_W = 2*COORD_BITS + $clog2(DIMS);

    logic                        en;
    logic [FIELD_W-1:0]          first_f  [SLOT_DIMS];
    logic [FIELD_W-1:0]          second_f [SLOT_DIMS];
    logic [DIMS-1:0][SQ_W-1:0]   sq;
    gks_ctl_t                    ctl_next;
    gks_ctl_t                    ctl1_reg;
    gks_ctl_t                    ctl2;
    gks_ctl_t                    ctl_out;
    logic [D2_W-1:0]             d2;
    logic [CFG_W-1:0]            inv_sigma_sq_reg;
    logic [SIM_W-1:0]            similarity;

    // Advance whenever the output register is empty or being drained
    assign en         = !result.valid || result.ready;
    assign pair.ready = en;
    assign cfg.ready  = 1'b1;

    assign first_f[0]  = pair.first_c0;
    assign first_f[1]  = pair.first_c1;
    assign first_f[2]  = pair.first_c2;
    assign first_f[3]  = pair.first_c3;
    assign second_f[0] = pair.second_c0;
    assign second_f[1] = pair.second_c1;
    assign second_f[2] = pair.second_c2;
    assign second_f[3] = pair.second_c3;

    assign ctl_next.valid     = pair.valid;
    assign ctl_next.self_pair = pair.self_pair;

    // Hold the kernel width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_sigma_sq_reg <= INV_SIGMA_RESET;
        end
        else if (cfg.valid)
        begin
            inv_sigma_sq_reg <= cfg.inv_sigma_sq;
        end
    end

    // Lane stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_next;
        end
    end

    // One lane per coordinate
    for (genvar d = 0; d < DIMS; d++)
    begin : g_lane
        gks_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .a   (first_f[d]),
            .b   (second_f[d]),
            .sq  (sq[d])
        );
    end

    gks_merge #(
        .DIMS       (DIMS),
        .COORD_BITS (COORD_BITS),
        .D2_W       (D2_W)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .sq      (sq),
        .ctl_in  (ctl1_reg),
        .d2      (d2),
        .ctl_out (ctl2)
    );

    gks_exp #(
        .D2_W (D2_W)
    ) u_exp (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .d2           (d2),
        .inv_sigma_sq (inv_sigma_sq_reg),
        .ctl_in       (ctl2),
        .similarity   (similarity),
        .ctl_out      (ctl_out)
    );

    assign result.valid      = ctl_out.valid;
    assign result.similarity = similarity;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for gaussian_kernel_similarity: directed table, then random pairs
// over several inv_sigma_sq settings and idling patterns, checked against a built-in predictor.
// Depends on gks_pkg, gks_pair_if, gks_result_if, gks_cfg_if and the block itself.
module testbench;
    import gks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int N_DIRECTED   = 22;

    localparam logic [CFG_W-1:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [CFG_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // Own constants for the exponential: log2(e) in Q.16, exponent cap 32.0
    localparam logic [63:0] LOG2E    = 64'd94548;
    localparam logic [63:0] EXPO_CAP = 64'h0020_0000;
    localparam logic [16:0] EXP2_FRAC [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    // Points packed as {c3, c2, c1, c0}
    typedef struct packed {
        logic [SLOT_DIMS*FIELD_W-1:0] first_pt;
        logic [SLOT_DIMS*FIELD_W-1:0] second_pt;
        logic                         self_pair;
    } pair_beat_t;

    typedef struct packed {
        logic [CFG_W-1:0]             inv_sigma_sq;
        logic [SLOT_DIMS*FIELD_W-1:0] first_pt;
        logic [SLOT_DIMS*FIELD_W-1:0] second_pt;
        logic                         self_pair;
        logic                         known;
        logic [SIM_W-1:0]             similarity;
    } stim_row_t;

    // Directed rows; similarity is only filled in where known is set
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // coincident points, self pairs and the widest spread at 1.0
        '{ONE_Q24, 64'h0, 64'h0, 1'b0, 1'b1, 16'hFFFF},
        '{ONE_Q24, 64'h0, 64'h0, 1'b1, 1'b1, 16'h0000},
        '{ONE_Q24, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 1'b0, 1'b1, 16'h0000},
        '{ONE_Q24, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 1'b1, 16'h0000},
        '{ONE_Q24, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 1'b1, 1'b1, 16'h0000},
        '{ONE_Q24, 64'h1234_A5A5_FFFF_8001, 64'h1234_A5A5_FFFF_8001, 1'b0, 1'b1, 16'hFFFF},
        // single-coordinate offsets covering every lane, then an offset on all four lanes
        '{ONE_Q24, 64'h0000_0000_0000_0001, 64'h0, 1'b0, 1'b0, 16'h0},
        '{ONE_Q24, 64'h0000_0100_0000_0000, 64'h0, 1'b0, 1'b0, 16'h0},
        '{ONE_Q24, 64'h0080_0000_0000_0000, 64'h0, 1'b0, 1'b0, 16'h0},
        '{ONE_Q24, 64'h0, 64'h0000_0000_0100_0000, 1'b0, 1'b0, 16'h0},
        '{ONE_Q24, 64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0001, 1'b0, 1'b0, 16'h0},
        '{ONE_Q24, 64'h0040_0040_0040_0040, 64'hFFC0_FFC0_FFC0_FFC0, 1'b0, 1'b0, 16'h0},
        // zero inv_sigma_sq: everything but a self pair saturates
        '{32'h0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 1'b0, 1'b1, 16'hFFFF},
        '{32'h0, 64'h0, 64'h0, 1'b0, 1'b1, 16'hFFFF},
        '{32'h0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 16'h0000},
        // largest inv_sigma_sq, product overflow on the widest spread
        '{ALL_ONES, 64'h0000_0000_0000_0001, 64'h0, 1'b0, 1'b0, 16'h0},
        '{ALL_ONES, 64'h0, 64'h0, 1'b0, 1'b1, 16'hFFFF},
        '{ALL_ONES, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 1'b0, 1'b1, 16'h0000},
        '{ALL_ONES, 64'h0010_0000_0000_0000, 64'h0, 1'b0, 1'b0, 16'h0},
        // smallest nonzero inv_sigma_sq and a quarter scale
        '{32'h1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 1'b0, 1'b0, 16'h0},
        '{32'h1, 64'h0000_0000_0000_0001, 64'h0, 1'b0, 1'b0, 16'h0},
        '{32'h0040_0000, 64'h0000_0000_0000_0300, 64'h0, 1'b0, 1'b0, 16'h0}
    };

    logic clk;
    logic rst_n;

    gks_pair_if   pair_ch ();
    gks_result_if result_ch ();
    gks_cfg_if    cfg_ch ();

    gaussian_kernel_similarity u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic [SIM_W-1:0] pending_similarity [$];
    logic [CFG_W-1:0] inv_sigma_model = ONE_Q24;
    logic             known_beat;
    logic [SIM_W-1:0] known_sim;
    int               gap_pct     = 0;
    int               stall_pct   = 0;
    int               cycle_count = 0;
    int               n_errors    = 0;
    int               n_pairs     = 0;
    int               n_results   = 0;
    int               n_self      = 0;
    int               n_full      = 0;
    int               n_zero      = 0;
    int               n_cfg       = 0;

    // Sign-extend the low COORD_BITS of a field
    function automatic logic signed [63:0] coord_of(input logic [FIELD_W-1:0] raw);
        return $signed(64'(raw) << (64 - GKS_COORD_BITS)) >>> (64 - GKS_COORD_BITS);
    endfunction

    // exp(-|p-q|^2 * inv) as Q0.16 via 2^(-y): table, interpolation, shift
    function automatic logic [SIM_W-1:0] kernel_similarity(input pair_beat_t b,
                                                           input logic [CFG_W-1:0] inv);
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic [63:0]        dist_sq;
        logic [127:0]       scaled;
        logic [63:0]        expo;
        logic [63:0]        log2_expo;
        logic [63:0]        whole;
        logic [63:0]        hi;
        logic [63:0]        lo;
        logic [63:0]        val;
        if (b.self_pair)
            return '0;
        dist_sq = '0;
        for (int i = 0; i < GKS_DIMS; i++)
        begin
            diff = coord_of(b.first_pt[i*FIELD_W +: FIELD_W])
                 - coord_of(b.second_pt[i*FIELD_W +: FIELD_W]);
            mag = (diff < 0) ? 64'(-diff) : 64'(diff);
            dist_sq += mag * mag;
        end
        scaled = (128'(dist_sq) * 128'(inv)) >> 24;
        expo = (scaled > 128'(EXPO_CAP)) ? EXPO_CAP : scaled[63:0];
        log2_expo = (expo * LOG2E) >> 16;
        whole = log2_expo >> 16;
        if (whole >= 64'd17)
            return '0;
        hi = 64'(EXP2_FRAC[int'(log2_expo[15:12])]);
        lo = 64'(EXP2_FRAC[int'(log2_expo[15:12]) + 1]);
        val = hi - (((hi - lo) * 64'(log2_expo[11:0])) >> 12);
        val = val >> whole;
        return (val > 64'd65535) ? 16'hFFFF : val[15:0];
    endfunction

    // Mostly nearby points at a random scale, plus wide, self and coincident pairs
    function automatic pair_beat_t random_pair_beat();
        pair_beat_t         b;
        int unsigned        pick;
        int unsigned        span;
        logic [FIELD_W-1:0] delta;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, FIELD_W - 1);
        b.first_pt  = {$urandom, $urandom};
        b.second_pt = {$urandom, $urandom};
        b.self_pair = (pick >= 85 && pick < 95);
        if (pick < 60)
        begin
            for (int i = 0; i < SLOT_DIMS; i++)
            begin
                delta = FIELD_W'($urandom_range(0, (1 << span) - 1));
                if ($urandom_range(0, 1))
                    delta = -delta;
                b.second_pt[i*FIELD_W +: FIELD_W] = b.first_pt[i*FIELD_W +: FIELD_W] + delta;
            end
        end
        else if (pick >= 95)
        begin
            b.second_pt = b.first_pt;
        end
        return b;
    endfunction

    // Present one pair after a random gap and hold it until accepted
    task automatic send_pair(input pair_beat_t b, input logic known,
                             input logic [SIM_W-1:0] sim);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        {pair_ch.first_c3, pair_ch.first_c2, pair_ch.first_c1, pair_ch.first_c0} <= b.first_pt;
        {pair_ch.second_c3, pair_ch.second_c2, pair_ch.second_c1, pair_ch.second_c0}
            <= b.second_pt;
        pair_ch.self_pair <= b.self_pair;
        known_beat <= known;
        known_sim  <= sim;
        do
            @(posedge clk);
        while (!pair_ch.ready);
    endtask

    // Drop valid and hold until every pending similarity has come back
    task automatic wait_for_results();
        pair_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_similarity.size() != 0);
    endtask

    task automatic write_inv_sigma(input logic [CFG_W-1:0] value);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.inv_sigma_sq <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: stall at the rate of the current phase
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Track register writes, predict accepted pairs, check returned similarities
    always @(posedge clk)
    begin
        logic [SIM_W-1:0] want;
        pair_beat_t       beat;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                inv_sigma_model = cfg_ch.inv_sigma_sq;
                n_cfg++;
            end
            if (pair_ch.valid && pair_ch.ready)
            begin
                beat.first_pt  = {pair_ch.first_c3, pair_ch.first_c2,
                                  pair_ch.first_c1, pair_ch.first_c0};
                beat.second_pt = {pair_ch.second_c3, pair_ch.second_c2,
                                  pair_ch.second_c1, pair_ch.second_c0};
                beat.self_pair = pair_ch.self_pair;
                pending_similarity.push_back(known_beat ? known_sim
                                             : kernel_similarity(beat, inv_sigma_model));
                n_pairs++;
                if (beat.self_pair)
                    n_self++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                n_results++;
                if (pending_similarity.size() == 0)
                begin
                    $display("%0t ns: unexpected similarity beat, expected none, actual %0d",
                             $time, result_ch.similarity);
                    n_errors++;
                end
                else
                begin
                    want = pending_similarity.pop_front();
                    if (want == 16'hFFFF)
                        n_full++;
                    if (want == 16'h0000)
                        n_zero++;
                    if (result_ch.similarity !== want)
                    begin
                        $display("%0t ns: similarity mismatch, expected %0d, actual %0d",
                                 $time, want, result_ch.similarity);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Bound the run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: run limit of %0d cycles reached, %0d results pending",
                 $time, CYCLE_LIMIT, pending_similarity.size());
        $display("** gaussian_kernel_similarity: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] setting;
        rst_n               = 1'b0;
        pair_ch.valid       = 1'b0;
        pair_ch.first_c0    = '0;
        pair_ch.first_c1    = '0;
        pair_ch.first_c2    = '0;
        pair_ch.first_c3    = '0;
        pair_ch.second_c0   = '0;
        pair_ch.second_c1   = '0;
        pair_ch.second_c2   = '0;
        pair_ch.second_c3   = '0;
        pair_ch.self_pair   = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.inv_sigma_sq = '0;
        result_ch.ready     = 1'b0;
        known_beat          = 1'b0;
        known_sim           = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, starting from the reset value of inv_sigma_sq
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (DIRECTED_ROWS[r].inv_sigma_sq != inv_sigma_model)
            begin
                wait_for_results();
                write_inv_sigma(DIRECTED_ROWS[r].inv_sigma_sq);
            end
            send_pair(pair_beat_t'{DIRECTED_ROWS[r].first_pt, DIRECTED_ROWS[r].second_pt,
                                   DIRECTED_ROWS[r].self_pair},
                      DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].similarity);
        end

        // Random phases: each idling pattern twice, a fresh register setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       setting = ONE_Q24;
                1:       setting = '0;
                5:       setting = ALL_ONES;
                default: setting = ($urandom | 32'h8000_0000) >> $urandom_range(0, 24);
            endcase
            if (phase == 6)
                setting = $urandom;
            write_inv_sigma(setting);
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 73; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 73; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the sender mid-phase until the pipeline has emptied
                if (n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_pair(random_pair_beat(), 1'b0, '0);
            end
        end

        // Drain, then watch a little longer for stray beats
        wait_for_results();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (pending_similarity.size() != 0)
        begin
            $display("%0t ns: %0d expected similarities never arrived",
                     $time, pending_similarity.size());
            n_errors += pending_similarity.size();
        end

        $display("Covered %0d pairs (%0d self pairs, %0d at 1.0, %0d at zero), %0d results,",
                 n_pairs, n_self, n_full, n_zero, n_results);
        $display("over %0d inv_sigma_sq writes and four idling patterns; %0d mismatches.",
                 n_cfg, n_errors);
        if (n_errors == 0)
            $display("** gaussian_kernel_similarity: PASSED **");
        else
            $display("** gaussian_kernel_similarity: FAILED **");
        $finish;
    end

endmodule
